// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the sphere/box contact block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define SOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define SOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/soc_pkg.sv =====
// Types and constants shared by the sphere/box contact pipeline.
package soc_pkg;

  localparam int D2W      = 56;  // squared distance, Q.16
  localparam int RTW      = 28;  // root and delta magnitude width
  localparam int SQ_STEPS = 28;  // one root bit per stage
  localparam int QW       = 15;  // normal quotient magnitude bits
  localparam int REMW     = 43;  // divider remainder width

  typedef struct packed {
    logic                 hit;
    logic                 zero;
    logic [15:0]          radius;
    logic [47:0]          axis_y;
    logic [2:0]           sgn;
    logic [2:0][RTW-1:0]  mag;
  } ctx_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        penetration;
  } out_item_t;

endpackage

// ===== hw/rtl/soc_in_if.sv =====
// Input channel: one sphere and one oriented box per word.
interface soc_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] sphere_center;
  logic [15:0] sphere_radius;
  logic [47:0] box_center;
  logic [47:0] box_half_size;
  logic [47:0] box_axis_x;
  logic [47:0] box_axis_y;
  logic [47:0] box_axis_z;

  modport source (
    output valid, sphere_center, sphere_radius, box_center, box_half_size,
           box_axis_x, box_axis_y, box_axis_z,
    input  ready
  );
  modport sink (
    input  valid, sphere_center, sphere_radius, box_center, box_half_size,
           box_axis_x, box_axis_y, box_axis_z,
    output ready
  );
endinterface

// ===== hw/rtl/soc_out_if.sv =====
// Result channel: contact flag, normal and depth per word.
interface soc_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [15:0]        penetration;

  modport source (
    output valid, hit, normal_x, normal_y, normal_z, penetration,
    input  ready
  );
  modport sink (
    input  valid, hit, normal_x, normal_y, normal_z, penetration,
    output ready
  );
endinterface

// ===== hw/rtl/soc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module soc_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     v_i,
  input  logic [soc_pkg::D2W-1:0]  d2_i,
  input  soc_pkg::ctx_t            ctx_i,
  output logic                     v_o,
  output logic [soc_pkg::RTW-1:0]  root_o,
  output soc_pkg::ctx_t            ctx_o
);
  localparam int NS = soc_pkg::SQ_STEPS;
  localparam int W  = soc_pkg::D2W + 1;

  logic [NS-1:0]  v_r;
  logic [W-1:0]   rem_r  [NS];
  logic [W-1:0]   root_r [NS];
  soc_pkg::ctx_t  ctx_r  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (2 * (NS - 1 - s));
    logic [W-1:0]  rem_in;
    logic [W-1:0]  root_in;
    logic [W-1:0]  trial;
    logic          v_in;
    logic          take;
    soc_pkg::ctx_t ctx_in;

    if (s == 0) begin : g_first
      assign rem_in  = {1'b0, d2_i};
      assign root_in = '0;
      assign v_in    = v_i;
      assign ctx_in  = ctx_i;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign v_in    = v_r[s-1];
      assign ctx_in  = ctx_r[s-1];
    end

    assign trial = root_in + BIT;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s]  <= take ? (rem_in - trial) : rem_in;
        root_r[s] <= take ? ((root_in >> 1) + BIT) : (root_in >> 1);
        ctx_r[s]  <= ctx_in;
      end
    end
  end

  assign v_o    = v_r[NS-1];
  assign root_o = root_r[NS-1][soc_pkg::RTW-1:0];
  assign ctx_o  = ctx_r[NS-1];
endmodule

// ===== hw/rtl/soc_div.sv =====
// Pipelined restoring divider: three normal components over the distance.
module soc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           v_i,
  input  logic [soc_pkg::RTW-1:0]        d_i,
  input  soc_pkg::ctx_t                  ctx_i,
  output logic                           v_o,
  output logic [2:0][soc_pkg::QW-1:0]    q_o,
  output logic [soc_pkg::RTW-1:0]        d_o,
  output soc_pkg::ctx_t                  ctx_o
);
  localparam int NQ = soc_pkg::QW;
  localparam int RW = soc_pkg::REMW;
  localparam int DW = soc_pkg::RTW;

  logic [NQ-1:0]         v_r;
  logic [2:0][RW-1:0]    rem_r [NQ];
  logic [2:0][NQ-1:0]    q_r   [NQ];
  logic [DW-1:0]         d_r   [NQ];
  soc_pkg::ctx_t         ctx_r [NQ];

  for (genvar s = 0; s < NQ; s++) begin : g_stage
    localparam int B = NQ - 1 - s;
    logic [2:0][RW-1:0]  rem_in;
    logic [2:0][NQ-1:0]  q_in;
    logic [2:0][RW-1:0]  rem_nxt;
    logic [2:0][NQ-1:0]  q_nxt;
    logic [DW-1:0]       d_in;
    logic [RW-1:0]       dsh;
    logic                v_in;
    soc_pkg::ctx_t       ctx_in;

    if (s == 0) begin : g_first
      // numerator: magnitude in Q.22 plus half the divisor for rounding
      for (genvar i = 0; i < 3; i++) begin : g_num
        assign rem_in[i] = {1'b0, ctx_i.mag[i], 14'b0} + RW'(d_i[DW-1:1]);
      end
      assign q_in   = '0;
      assign d_in   = d_i;
      assign v_in   = v_i;
      assign ctx_in = ctx_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign q_in   = q_r[s-1];
      assign d_in   = d_r[s-1];
      assign v_in   = v_r[s-1];
      assign ctx_in = ctx_r[s-1];
    end

    assign dsh = RW'(d_in) << B;

    always_comb begin
      rem_nxt = rem_in;
      q_nxt   = q_in;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= dsh) begin
          rem_nxt[i] = rem_in[i] - dsh;
          q_nxt[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= rem_nxt;
        q_r[s]   <= q_nxt;
        d_r[s]   <= d_in;
        ctx_r[s] <= ctx_in;
      end
    end
  end

  assign v_o   = v_r[NQ-1];
  assign q_o   = q_r[NQ-1];
  assign d_o   = d_r[NQ-1];
  assign ctx_o = ctx_r[NQ-1];
endmodule

// ===== hw/rtl/sphere_obb_contact.sv =====
// Sphere against oriented box contact test, fully pipelined top level.
//
//   channel | direction | word
//   in_if   | sink      | sphere center/radius, box center/half size/axes
//   out_if  | source    | hit, normal x/y/z (Q2.14), penetration (Q16.0)
//
// One word is accepted per cycle while the skid entry is empty; a result passes through
// 50 registers: 6 geometry stages, 28 square-root stages (one root bit each),
// 15 divider stages (one quotient bit each) and the output register.
// Reset clears every stage valid bit and the two-entry output buffer.
// The pipeline advances while the skid entry is empty, so a word is still
// accepted while one finished result waits at the output.
`include "assert_macros.svh"

module sphere_obb_contact (
  input  logic      clk,
  input  logic      rst_n,
  soc_in_if.sink    in_if,
  soc_out_if.source out_if
);
  localparam int RTW = soc_pkg::RTW;
  localparam int D2W = soc_pkg::D2W;

  logic adv;

  // unpacked inputs
  logic signed [15:0] sc [3];
  logic signed [15:0] bc [3];
  logic signed [15:0] ax [3][3];
  logic [15:0]        hs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sc[i]    = in_if.sphere_center[16*i +: 16];
      bc[i]    = in_if.box_center[16*i +: 16];
      hs[i]    = in_if.box_half_size[16*i +: 16];
      ax[0][i] = in_if.box_axis_x[16*i +: 16];
      ax[1][i] = in_if.box_axis_y[16*i +: 16];
      ax[2][i] = in_if.box_axis_z[16*i +: 16];
    end
  end

  // stage A: local offset and its projections
  logic signed [16:0] loc_nxt [3];
  logic signed [32:0] pa_nxt  [3][3];
  logic               va_r;
  logic signed [16:0] loc_a_r [3];
  logic signed [32:0] pa_a_r  [3][3];
  logic signed [15:0] ax_a_r  [3][3];
  logic [15:0]        hs_a_r  [3];
  logic [15:0]        rad_a_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      loc_nxt[i] = 17'(sc[i]) - 17'(bc[i]);
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        pa_nxt[k][i] = 33'(loc_nxt[i]) * 33'(ax[k][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      loc_a_r <= loc_nxt;
      pa_a_r  <= pa_nxt;
      ax_a_r  <= ax;
      hs_a_r  <= hs;
      rad_a_r <= in_if.sphere_radius;
    end
  end

  // stage B: sum and clamp to the half extents
  logic signed [34:0] ps  [3];
  logic signed [34:0] hp  [3];
  logic signed [34:0] hn  [3];
  logic signed [30:0] cl_nxt [3];
  logic               vb_r;
  logic signed [30:0] cl_b_r  [3];
  logic signed [16:0] loc_b_r [3];
  logic signed [15:0] ax_b_r  [3][3];
  logic [15:0]        rad_b_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ps[k] = 35'(pa_a_r[k][0]) + 35'(pa_a_r[k][1]) + 35'(pa_a_r[k][2]);
      hp[k] = $signed({5'b0, hs_a_r[k], 14'b0});
      hn[k] = -hp[k];
      if (ps[k] > hp[k]) begin
        cl_nxt[k] = hp[k][30:0];
      end else if (ps[k] < hn[k]) begin
        cl_nxt[k] = hn[k][30:0];
      end else begin
        cl_nxt[k] = ps[k][30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cl_b_r  <= cl_nxt;
      loc_b_r <= loc_a_r;
      ax_b_r  <= ax_a_r;
      rad_b_r <= rad_a_r;
    end
  end

  // stage C: closest point terms
  logic signed [46:0] po_nxt [3][3];
  logic               vc_r;
  logic signed [46:0] po_c_r  [3][3];
  logic signed [16:0] loc_c_r [3];
  logic [47:0]        axy_c_r;
  logic [15:0]        rad_c_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        po_nxt[i][k] = 47'(ax_b_r[k][i]) * 47'(cl_b_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      po_c_r  <= po_nxt;
      loc_c_r <= loc_b_r;
      axy_c_r <= {ax_b_r[1][2], ax_b_r[1][1], ax_b_r[1][0]};
      rad_c_r <= rad_b_r;
    end
  end

  // stage D: delta, rounded half away from zero to Q.8
  logic signed [49:0] raw  [3];
  logic [49:0]        mraw [3];
  logic [49:0]        mrnd [3];
  logic [RTW-1:0]     mag_nxt [3];
  logic [2:0]         sgn_nxt;
  logic               vd_r;
  logic [RTW-1:0]     mag_d_r [3];
  logic [2:0]         sgn_d_r;
  logic [47:0]        axy_d_r;
  logic [15:0]        rad_d_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      raw[i] = (50'(loc_c_r[i]) <<< 28)
             - (50'(po_c_r[i][0]) + 50'(po_c_r[i][1]) + 50'(po_c_r[i][2]));
      sgn_nxt[i] = raw[i][49];
      mraw[i] = raw[i][49] ? 50'(-raw[i]) : 50'(raw[i]);
      mrnd[i] = mraw[i] + 50'd524288;
      mag_nxt[i] = mrnd[i][RTW+19:20];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_d_r <= mag_nxt;
      sgn_d_r <= sgn_nxt;
      axy_d_r <= axy_c_r;
      rad_d_r <= rad_c_r;
    end
  end

  // stage E: squares
  logic               ve_r;
  logic [D2W-1:0]     sq_e_r  [3];
  logic [47:0]        r2_e_r;
  logic [RTW-1:0]     mag_e_r [3];
  logic [2:0]         sgn_e_r;
  logic [47:0]        axy_e_r;
  logic [15:0]        rad_e_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_e_r[i] <= D2W'(mag_d_r[i]) * D2W'(mag_d_r[i]);
      end
      r2_e_r  <= 48'({rad_d_r, 8'b0}) * 48'({rad_d_r, 8'b0});
      mag_e_r <= mag_d_r;
      sgn_e_r <= sgn_d_r;
      axy_e_r <= axy_d_r;
      rad_e_r <= rad_d_r;
    end
  end

  // stage F: distance against radius
  logic [D2W-1:0] d2_nxt;
  soc_pkg::ctx_t  ctx_nxt;
  logic           vf_r;
  logic [D2W-1:0] d2_f_r;
  soc_pkg::ctx_t  ctx_f_r;

  always_comb begin
    d2_nxt         = sq_e_r[0] + sq_e_r[1] + sq_e_r[2];
    ctx_nxt.hit    = (d2_nxt <= D2W'(r2_e_r));
    ctx_nxt.zero   = (d2_nxt == '0);
    ctx_nxt.radius = rad_e_r;
    ctx_nxt.axis_y = axy_e_r;
    ctx_nxt.sgn    = sgn_e_r;
    for (int i = 0; i < 3; i++) begin
      ctx_nxt.mag[i] = mag_e_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_f_r  <= d2_nxt;
      ctx_f_r <= ctx_nxt;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_if.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  // root and normal division
  logic           sq_v;
  logic [RTW-1:0] sq_root;
  soc_pkg::ctx_t  sq_ctx;

  soc_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .v_i    (vf_r),
    .d2_i   (d2_f_r),
    .ctx_i  (ctx_f_r),
    .v_o    (sq_v),
    .root_o (sq_root),
    .ctx_o  (sq_ctx)
  );

  logic                           dv_v;
  logic [2:0][soc_pkg::QW-1:0]    dv_q;
  logic [RTW-1:0]                 dv_d;
  soc_pkg::ctx_t                  dv_ctx;

  soc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .v_i   (sq_v),
    .d_i   (sq_root),
    .ctx_i (sq_ctx),
    .v_o   (dv_v),
    .q_o   (dv_q),
    .d_o   (dv_d),
    .ctx_o (dv_ctx)
  );

  // result assembly
  logic signed [15:0] nrm [3];
  logic [28:0]        rdiff;
  logic [27:0]        rrnd;
  logic [15:0]        pen;
  soc_pkg::out_item_t res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = dv_ctx.sgn[i] ? -$signed({1'b0, dv_q[i]}) : $signed({1'b0, dv_q[i]});
    end
    rdiff = {5'b0, dv_ctx.radius, 8'b0} - {1'b0, dv_d};
    rrnd  = rdiff[27:0] + 28'd128;
    pen   = rdiff[28] ? 16'd0 : rrnd[23:8];

    res = '0;
    if (dv_ctx.hit) begin
      res.hit = 1'b1;
      if (dv_ctx.zero) begin
        res.normal_x    = dv_ctx.axis_y[15:0];
        res.normal_y    = dv_ctx.axis_y[31:16];
        res.normal_z    = dv_ctx.axis_y[47:32];
        res.penetration = dv_ctx.radius;
      end else begin
        res.normal_x    = nrm[0];
        res.normal_y    = nrm[1];
        res.normal_z    = nrm[2];
        res.penetration = pen;
      end
    end
  end

  // two-entry output buffer: head word and skid word
  logic               out_v_r;
  logic               sk_v_r;
  soc_pkg::out_item_t out_d_r;
  soc_pkg::out_item_t sk_d_r;
  logic               push;
  logic               pop;

  assign adv         = !sk_v_r;
  assign in_if.ready = adv;
  assign push        = adv & dv_v;
  assign pop         = out_v_r & out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (pop) begin
      if (sk_v_r) begin
        sk_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (!out_v_r) begin
      out_v_r <= push;
    end else if (push) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && sk_v_r) begin
      out_d_r <= sk_d_r;
    end else if (pop || !out_v_r) begin
      out_d_r <= res;
    end else if (push) begin
      sk_d_r <= res;
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.hit         = out_d_r.hit;
  assign out_if.normal_x    = out_d_r.normal_x;
  assign out_if.normal_y    = out_d_r.normal_y;
  assign out_if.normal_z    = out_d_r.normal_z;
  assign out_if.penetration = out_d_r.penetration;

  `SOC_ASSERT_NOW(a_skid_behind_head, sk_v_r, out_v_r, "skid word held without a head word")
  `SOC_ASSERT_NOW(a_miss_is_zero, out_v_r && !out_d_r.hit,
                  out_d_r.normal_x == 16'sd0 && out_d_r.normal_y == 16'sd0 &&
                  out_d_r.normal_z == 16'sd0 && out_d_r.penetration == 16'd0,
                  "miss word carries nonzero normal or depth")
  `SOC_ASSERT_NEXT(a_skid_drain, sk_v_r && out_if.ready, out_v_r && !sk_v_r,
                   "skid word not moved to head after pop")
endmodule

// ===== tb/sv/tb_soc_channels.sv =====
// Channel interfaces as the testbench sees them are the RTL ones; this file holds shared tb types.
package tb_soc_types;
  typedef struct {
    logic [47:0] sc;
    logic [15:0] sr;
    logic [47:0] bc;
    logic [47:0] hs;
    logic [47:0] ax;
    logic [47:0] ay;
    logic [47:0] az;
  } pair_t;
endpackage

// ===== tb/sv/tb_sphere_obb_contact.sv =====
// Testbench for sphere_obb_contact: directed and random sphere/box pairs checked against a predictor.
module tb_sphere_obb_contact;
  timeunit 1ns;
  timeprecision 1ps;
  import soc_pkg::*;
  import tb_soc_types::*;

  localparam int LATENCY = 50;
  localparam logic [15:0] UNIT = 16'sd16384;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  soc_in_if  in_ch();
  soc_out_if out_ch();

  sphere_obb_contact dut (.clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch));

  out_item_t contact_q[$];
  int        mismatches = 0;
  bit        idle_on = 1'b1;

  function automatic longint sc16(logic [47:0] v, int i);
    return longint'($signed(v[16*i +: 16]));
  endfunction

  function automatic longint rnd_shift20(longint v);
    if (v >= 0) return (v + (64'sd1 <<< 19)) >>> 20;
    return -((-v + (64'sd1 <<< 19)) >>> 20);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_item_t contact_of(pair_t p);
    longint loc[3], ax[3][3], cl[3], dl[3], pr, h, off;
    longint unsigned d2, r16, r2, d, mag, q, dep;
    out_item_t o;
    d2 = 0;
    o = '0;
    for (int i = 0; i < 3; i++) begin
      loc[i] = sc16(p.sc, i) - sc16(p.bc, i);
      ax[0][i] = sc16(p.ax, i);
      ax[1][i] = sc16(p.ay, i);
      ax[2][i] = sc16(p.az, i);
    end
    for (int k = 0; k < 3; k++) begin
      h = longint'(p.hs[16*k +: 16]) * 16384;
      pr = 0;
      for (int i = 0; i < 3; i++) pr += loc[i] * ax[k][i];
      if (pr > h) pr = h;
      if (pr < -h) pr = -h;
      cl[k] = pr;
    end
    for (int i = 0; i < 3; i++) begin
      off = 0;
      for (int k = 0; k < 3; k++) off += ax[k][i] * cl[k];
      dl[i] = rnd_shift20(loc[i] * (64'sd1 <<< 28) - off);
      d2 += longint'(dl[i] * dl[i]);
    end
    r16 = longint'(p.sr) << 8;
    r2 = r16 * r16;
    if (d2 > r2) return o;
    o.hit = 1'b1;
    if (d2 == 0) begin
      o.normal_x = p.ay[15:0];
      o.normal_y = p.ay[31:16];
      o.normal_z = p.ay[47:32];
      o.penetration = p.sr;
      return o;
    end
    d = int_sqrt(d2);
    for (int i = 0; i < 3; i++) begin
      longint s;
      mag = (dl[i] < 0) ? -dl[i] : dl[i];
      q = (mag * 16384 + d / 2) / d;
      s = (q > 32768) ? 32768 : longint'(q);
      if (dl[i] < 0) s = -s;
      if (s > 32767) s = 32767;
      case (i)
        0: o.normal_x = s[15:0];
        1: o.normal_y = s[15:0];
        default: o.normal_z = s[15:0];
      endcase
    end
    dep = (r16 >= d) ? ((r16 - d + 128) >> 8) : 0;
    if (dep > 65535) dep = 65535;
    o.penetration = dep[15:0];
    return o;
  endfunction

  // drive at a falling edge (idling may add a random gap), keep valid high between back-to-back words
  task automatic send_pair(pair_t p);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sphere_center <= p.sc;
    in_ch.sphere_radius <= p.sr;
    in_ch.box_center <= p.bc;
    in_ch.box_half_size <= p.hs;
    in_ch.box_axis_x <= p.ax;
    in_ch.box_axis_y <= p.ay;
    in_ch.box_axis_z <= p.az;
    do @(posedge clk); while (!in_ch.ready);
    contact_q.push_back(contact_of(p));
  endtask

  // hold ready low in random bursts while idling is enabled
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (contact_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word hit=%0b", out_ch.hit);
      end else begin
        out_item_t e;
        e = contact_q.pop_front();
        if (out_ch.hit !== e.hit || out_ch.normal_x !== e.normal_x ||
            out_ch.normal_y !== e.normal_y || out_ch.normal_z !== e.normal_z ||
            out_ch.penetration !== e.penetration) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp hit=%0b n=%0d,%0d,%0d pen=%0d got hit=%0b n=%0d,%0d,%0d pen=%0d",
                     e.hit, e.normal_x, e.normal_y, e.normal_z, e.penetration,
                     out_ch.hit, out_ch.normal_x, out_ch.normal_y, out_ch.normal_z,
                     out_ch.penetration);
        end
      end
    end
  end

  function automatic logic [47:0] vec3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic pair_t axis_box(logic [47:0] sc, logic [15:0] sr, logic [47:0] hs);
    pair_t p;
    p.sc = sc; p.sr = sr; p.bc = '0; p.hs = hs;
    p.ax = vec3(UNIT, 0, 0); p.ay = vec3(0, UNIT, 0); p.az = vec3(0, 0, UNIT);
    return p;
  endfunction

  function automatic logic [15:0] near16();
    return 16'($signed($urandom_range(0, 4096)) - 2048);
  endfunction

  // random unit-ish axes: permutations with signs, a 45-degree rotation about Z, or raw noise
  function automatic pair_t rand_pair(bit noise);
    pair_t p;
    int perm;
    logic [15:0] s[3];
    p.sc = noise ? 48'({$urandom, $urandom}) : vec3(near16(), near16(), near16());
    p.bc = noise ? 48'({$urandom, $urandom}) : vec3(near16(), near16(), near16());
    p.hs = noise ? 48'({$urandom, $urandom}) :
           vec3(16'($urandom_range(0, 1536)), 16'($urandom_range(0, 1536)),
                16'($urandom_range(0, 1536)));
    p.sr = noise ? 16'($urandom) : 16'($urandom_range(0, 2048));
    if (noise) begin
      p.ax = 48'({$urandom, $urandom});
      p.ay = 48'({$urandom, $urandom});
      p.az = 48'({$urandom, $urandom});
    end else begin
      for (int i = 0; i < 3; i++) s[i] = $urandom_range(0, 1) ? UNIT : -UNIT;
      perm = $urandom_range(0, 2);
      p.ax = '0; p.ay = '0; p.az = '0;
      p.ax[16*perm +: 16] = s[0];
      p.ay[16*((perm+1)%3) +: 16] = s[1];
      p.az[16*((perm+2)%3) +: 16] = s[2];
      if ($urandom_range(0, 3) == 0) begin
        // 45-degree rotation about Z, Q2.14 approx of 1/sqrt2
        p.ax = vec3(16'sd11585, 16'sd11585, 0);
        p.ay = vec3(-16'sd11585, 16'sd11585, 0);
        p.az = vec3(0, 0, UNIT);
      end
    end
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    send_pair(axis_box(0, 16'h0100, vec3(16'h0100, 16'h0100, 16'h0100)));   // center inside
    send_pair(axis_box(vec3(16'h0200, 0, 0), 16'h0100, vec3(16'h0100, 16'h0100, 16'h0100)));
    send_pair(axis_box(vec3(16'h0300, 0, 0), 16'h0100, vec3(16'h0100, 16'h0100, 16'h0100)));
    send_pair(axis_box(vec3(16'h0180, 16'h0180, 0), 16'h0100, vec3(16'h0100, 16'h0100, 0)));
    send_pair(axis_box(vec3(0, 0, 16'h0200), 0, vec3(16'h0100, 16'h0100, 16'h0100)));
    send_pair(axis_box(vec3(0, 0, 16'h0100), 0, vec3(16'h0100, 16'h0100, 16'h0100)));
    send_pair(axis_box(vec3(16'h8000, 16'h8000, 16'h8000), 16'hFFFF, 0));
    send_pair(axis_box(vec3(16'h7FFF, 16'h7FFF, 16'h7FFF), 16'hFFFF, 48'hFFFF_FFFF_FFFF));
    send_pair(axis_box(vec3(16'h7FFF, 16'h8000, 16'h7FFF), 16'hFFFF, 0));
    send_pair(axis_box(vec3(16'h0001, 0, 0), 16'h0001, 0));
    p = axis_box(vec3(16'h0100, 16'h0100, 0), 16'h0400, 0);
    p.ax = vec3(16'h7FFF, 16'h7FFF, 16'h7FFF);   // non-unit axes
    p.ay = vec3(16'h8000, 16'h8000, 16'h8000);
    p.az = '0;
    send_pair(p);
    p.ax = '0; p.ay = vec3(16'h1234, 16'h8001, 16'h7FFF); p.sc = 0;
    send_pair(p);
    p = rand_pair(1'b1); p.sr = 16'hFFFF;
    send_pair(p);
    for (int i = 0; i < 6; i++) send_pair(rand_pair(1'b1));
  endtask

  task automatic test_random(int n, bit idle);
    idle_on = idle;
    for (int i = 0; i < n; i++) send_pair(rand_pair($urandom_range(0, 9) == 0));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sphere_center = '0;
    in_ch.sphere_radius = '0;
    in_ch.box_center = '0;
    in_ch.box_half_size = '0;
    in_ch.box_axis_x = '0;
    in_ch.box_axis_y = '0;
    in_ch.box_axis_z = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(1100, 1'b1);
    test_random(230, 1'b0);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    fork
      wait (contact_q.size() == 0);
      repeat (200000) @(posedge clk);
    join_any
    disable fork;
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && contact_q.size() == 0) begin
      $display("[sphere_obb_contact] OK");
    end else begin
      $display("[sphere_obb_contact] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[sphere_obb_contact] ERROR");
    $finish;
  end
endmodule

// ===== sphere_obb_contact.f =====
+incdir+hw/rtl
hw/rtl/soc_pkg.sv
hw/rtl/soc_in_if.sv
hw/rtl/soc_out_if.sv
hw/rtl/soc_sqrt.sv
hw/rtl/soc_div.sv
hw/rtl/sphere_obb_contact.sv
tb/sv/tb_soc_channels.sv
tb/sv/tb_sphere_obb_contact.sv
